// File: rtl/qrs_pkg.sv
// Package: payload types, status codes and sizing constants of the quadratic root solver.
`default_nettype none
package qrs_pkg;

    localparam int COEF_WIDTH = 16;
    localparam int FRAC_BITS  = 16;
    localparam int ROOT_WIDTH = 48;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NEG_DISC  = 2'd1,
        ST_ZERO_LEAD = 2'd2
    } t_status;

    typedef struct packed {
        logic signed [COEF_WIDTH-1:0] coef_a;
        logic signed [COEF_WIDTH-1:0] coef_b;
        logic signed [COEF_WIDTH-1:0] coef_c;
        logic signed [COEF_WIDTH-1:0] rhs_value;
    } t_in;

    typedef struct packed {
        logic signed [ROOT_WIDTH-1:0] root_low;
        logic signed [ROOT_WIDTH-1:0] root_high;
        t_status                      solve_status;
    } t_out;

endpackage
`default_nettype wire

// File: rtl/quadratic_root_solver_top.sv
// Top level: fully pipelined real-root solver for a*x^2 + b*x + c = d.
//
//  channel | valid      | ready       | payload
//  --------+------------+-------------+------------------------------
//  input   | i_in_valid | o_in_ready  | i_in_data  (qrs_pkg::t_in)
//  output  | o_out_valid| i_out_ready | o_out_data (qrs_pkg::t_out)
//
// One transaction per cycle sustained while the receiver keeps taking results; the pipe has
// one stage per square-root bit and one per quotient bit.
// Reset (synchronous, active low) clears only the valid bits of every stage.
// The whole pipe advances when the output register is empty or being taken;
// a stall freezes every stage, so nothing is dropped or repeated.
`default_nettype none
module quadratic_root_solver_top #(
    parameter int FRAC_BITS = qrs_pkg::FRAC_BITS
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_in_valid,
    output logic                 o_in_ready,
    input  wire qrs_pkg::t_in    i_in_data,
    output logic                 o_out_valid,
    input  wire                  i_out_ready,
    output qrs_pkg::t_out        o_out_data
);

    localparam int CW  = qrs_pkg::COEF_WIDTH;
    localparam int RTW = qrs_pkg::ROOT_WIDTH;
    // discriminant magnitude width, square-root result width
    localparam int DW   = 2 * CW + 2;
    localparam int NS   = CW + 1 + FRAC_BITS;
    localparam int RADW = 2 * NS;
    localparam int REMW = NS + 3;
    // signed numerator width and its magnitude width (= quotient bits)
    localparam int NW  = CW + 3 + FRAC_BITS;
    localparam int MW  = NW - 1;
    localparam int DVW = CW + 1;
    localparam int QX  = ((MW > RTW) ? MW : RTW) + 1;
    localparam logic [QX-1:0] NEG_LIM = QX'(1) << (RTW - 1);
    localparam logic [QX-1:0] POS_MAX = NEG_LIM - QX'(1);

    // whole pipe moves together
    logic w_adv;
    logic r_out_valid;
    qrs_pkg::t_out r_out;

    assign w_adv       = ~r_out_valid | i_out_ready;
    assign o_in_ready  = w_adv;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // ---------------- stage 0: capture, e = c - d ----------------
    logic                 r_s0_vld;
    logic signed [CW-1:0] r_s0_a, r_s0_b;
    logic signed [CW:0]   r_s0_e;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_vld <= 1'b0;
        end else if (w_adv) begin
            r_s0_vld <= i_in_valid;
        end
        if (w_adv) begin
            r_s0_a <= i_in_data.coef_a;
            r_s0_b <= i_in_data.coef_b;
            r_s0_e <= (CW+1)'(i_in_data.coef_c) - (CW+1)'(i_in_data.rhs_value);
        end
    end

    // ---------------- stage 1: products b*b and a*e ----------------
    logic                     r_s1_vld;
    logic signed [CW-1:0]     r_s1_a, r_s1_b;
    logic signed [2*CW-1:0]   r_s1_bb;
    logic signed [2*CW:0]     r_s1_ae;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (w_adv) begin
            r_s1_vld <= r_s0_vld;
        end
        if (w_adv) begin
            r_s1_a  <= r_s0_a;
            r_s1_b  <= r_s0_b;
            r_s1_bb <= r_s0_b * r_s0_b;
            r_s1_ae <= r_s0_a * r_s0_e;
        end
    end

    // ---------------- square root: entry 0 forms D, one bit per stage ----------------
    logic [NS:0]             r_sq_vld;
    logic signed [CW-1:0]    r_sq_a    [0:NS];
    logic signed [CW-1:0]    r_sq_b    [0:NS];
    qrs_pkg::t_status        r_sq_st   [0:NS];
    logic [DW-1:0]           r_sq_d    [0:NS];
    logic [REMW-1:0]         r_sq_rem  [0:NS];
    logic [NS-1:0]           r_sq_root [0:NS];

    logic signed [DW:0]      s2_d;
    qrs_pkg::t_status        n_s2_st;

    always_comb begin
        s2_d = (DW+1)'(r_s1_bb) - ((DW+1)'(r_s1_ae) <<< 2);
        if (r_s1_a == '0) begin
            n_s2_st = qrs_pkg::ST_ZERO_LEAD;
        end else if (s2_d[DW]) begin
            n_s2_st = qrs_pkg::ST_NEG_DISC;
        end else begin
            n_s2_st = qrs_pkg::ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_vld[0] <= 1'b0;
        end else if (w_adv) begin
            r_sq_vld[0] <= r_s1_vld;
        end
        if (w_adv) begin
            r_sq_a[0]    <= r_s1_a;
            r_sq_b[0]    <= r_s1_b;
            r_sq_st[0]   <= n_s2_st;
            r_sq_d[0]    <= s2_d[DW-1:0];
            r_sq_rem[0]  <= '0;
            r_sq_root[0] <= '0;
        end
    end

    for (genvar j = 0; j < NS; j++) begin : g_sqrt
        localparam int POS = RADW - 2 - 2 * j;
        logic [1:0]      w_pair;
        logic [REMW-1:0] w_rem, w_trial;
        logic            w_ge;

        if (POS >= 2 * FRAC_BITS) begin : g_pair
            assign w_pair = r_sq_d[j][POS-2*FRAC_BITS +: 2];
        end else begin : g_zero
            assign w_pair = 2'b00;
        end

        assign w_rem   = {r_sq_rem[j][REMW-3:0], w_pair};
        assign w_trial = {1'b0, r_sq_root[j], 2'b01};
        assign w_ge    = (w_rem >= w_trial);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sq_vld[j+1] <= 1'b0;
            end else if (w_adv) begin
                r_sq_vld[j+1] <= r_sq_vld[j];
            end
            if (w_adv) begin
                r_sq_a[j+1]    <= r_sq_a[j];
                r_sq_b[j+1]    <= r_sq_b[j];
                r_sq_st[j+1]   <= r_sq_st[j];
                r_sq_d[j+1]    <= r_sq_d[j];
                r_sq_rem[j+1]  <= w_ge ? (w_rem - w_trial) : w_rem;
                r_sq_root[j+1] <= {r_sq_root[j][NS-2:0], w_ge};
            end
        end
    end

    // ---------------- numerators -b*2^F -/+ S, divisor |2a| ----------------
    logic                 r_n1_vld;
    qrs_pkg::t_status     r_n1_st;
    logic                 r_n1_an;
    logic signed [NW-1:0] r_n1_lo, r_n1_hi;
    logic [DVW-1:0]       r_n1_dvs;

    logic signed [NW-1:0] n1_b, n1_s;
    logic [CW-1:0]        n1_aa;

    always_comb begin
        n1_b  = NW'(r_sq_b[NS]) <<< FRAC_BITS;
        n1_s  = NW'(r_sq_root[NS]);
        n1_aa = r_sq_a[NS][CW-1] ? (~r_sq_a[NS] + 1'b1) : r_sq_a[NS];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n1_vld <= 1'b0;
        end else if (w_adv) begin
            r_n1_vld <= r_sq_vld[NS];
        end
        if (w_adv) begin
            r_n1_st  <= r_sq_st[NS];
            r_n1_an  <= r_sq_a[NS][CW-1];
            r_n1_lo  <= -n1_b - n1_s;
            r_n1_hi  <= -n1_b + n1_s;
            r_n1_dvs <= {n1_aa, 1'b0};
        end
    end

    // ---------------- dividers: entry 0 takes magnitudes, one quotient bit per stage ----
    logic [MW:0]          r_dv_vld;
    qrs_pkg::t_status     r_dv_st     [0:MW];
    logic                 r_dv_neg_lo [0:MW];
    logic                 r_dv_neg_hi [0:MW];
    logic [MW-1:0]        r_dv_mlo    [0:MW];
    logic [MW-1:0]        r_dv_mhi    [0:MW];
    logic [DVW-1:0]       r_dv_dvs    [0:MW];
    logic [DVW-1:0]       r_dv_rlo    [0:MW];
    logic [DVW-1:0]       r_dv_rhi    [0:MW];
    logic [MW-1:0]        r_dv_qlo    [0:MW];
    logic [MW-1:0]        r_dv_qhi    [0:MW];

    logic [NW-1:0] n2_mlo, n2_mhi;

    always_comb begin
        n2_mlo = r_n1_lo[NW-1] ? (~r_n1_lo + 1'b1) : r_n1_lo;
        n2_mhi = r_n1_hi[NW-1] ? (~r_n1_hi + 1'b1) : r_n1_hi;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv_vld[0] <= 1'b0;
        end else if (w_adv) begin
            r_dv_vld[0] <= r_n1_vld;
        end
        if (w_adv) begin
            r_dv_st[0]     <= r_n1_st;
            r_dv_neg_lo[0] <= r_n1_lo[NW-1] ^ r_n1_an;
            r_dv_neg_hi[0] <= r_n1_hi[NW-1] ^ r_n1_an;
            r_dv_mlo[0]    <= n2_mlo[MW-1:0];
            r_dv_mhi[0]    <= n2_mhi[MW-1:0];
            r_dv_dvs[0]    <= r_n1_dvs;
            r_dv_rlo[0]    <= '0;
            r_dv_rhi[0]    <= '0;
            r_dv_qlo[0]    <= '0;
            r_dv_qhi[0]    <= '0;
        end
    end

    for (genvar j = 0; j < MW; j++) begin : g_div
        logic [DVW:0] w_tlo, w_thi, w_dx;
        logic         w_glo, w_ghi;

        assign w_dx  = {1'b0, r_dv_dvs[j]};
        assign w_tlo = {r_dv_rlo[j], r_dv_mlo[j][MW-1-j]};
        assign w_thi = {r_dv_rhi[j], r_dv_mhi[j][MW-1-j]};
        assign w_glo = (w_tlo >= w_dx);
        assign w_ghi = (w_thi >= w_dx);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_vld[j+1] <= 1'b0;
            end else if (w_adv) begin
                r_dv_vld[j+1] <= r_dv_vld[j];
            end
            if (w_adv) begin
                r_dv_st[j+1]     <= r_dv_st[j];
                r_dv_neg_lo[j+1] <= r_dv_neg_lo[j];
                r_dv_neg_hi[j+1] <= r_dv_neg_hi[j];
                r_dv_mlo[j+1]    <= r_dv_mlo[j];
                r_dv_mhi[j+1]    <= r_dv_mhi[j];
                r_dv_dvs[j+1]    <= r_dv_dvs[j];
                r_dv_rlo[j+1]    <= w_glo ? DVW'(w_tlo - w_dx) : w_tlo[DVW-1:0];
                r_dv_rhi[j+1]    <= w_ghi ? DVW'(w_thi - w_dx) : w_thi[DVW-1:0];
                r_dv_qlo[j+1]    <= {r_dv_qlo[j][MW-2:0], w_glo};
                r_dv_qhi[j+1]    <= {r_dv_qhi[j][MW-2:0], w_ghi};
            end
        end
    end

    // ---------------- sign, saturation, output register ----------------
    function automatic logic [RTW-1:0] f_fix(input logic [MW-1:0] q, input logic neg);
        logic [QX-1:0]  qx;
        logic [QX-1:0]  nq;
        logic [RTW-1:0] res;
        qx = QX'(q);
        nq = ~qx + 1'b1;
        if (neg) begin
            res = (qx > NEG_LIM) ? NEG_LIM[RTW-1:0] : nq[RTW-1:0];
        end else begin
            res = (qx > POS_MAX) ? POS_MAX[RTW-1:0] : qx[RTW-1:0];
        end
        return res;
    endfunction

    qrs_pkg::t_out n_out;

    always_comb begin
        n_out.solve_status = r_dv_st[MW];
        if (r_dv_st[MW] == qrs_pkg::ST_OK) begin
            n_out.root_low  = f_fix(r_dv_qlo[MW], r_dv_neg_lo[MW]);
            n_out.root_high = f_fix(r_dv_qhi[MW], r_dv_neg_hi[MW]);
        end else begin
            n_out.root_low  = '0;
            n_out.root_high = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= r_dv_vld[MW];
        end
        if (w_adv) begin
            r_out <= n_out;
        end
    end

    // ---------------- assertions ----------------
    a_flag_zero_roots: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_out.solve_status != qrs_pkg::ST_OK)
        |-> (r_out.root_low == '0) && (r_out.root_high == '0))
        else $error("flagged transaction carries nonzero roots");

    a_zero_lead_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dv_vld[MW] && (r_dv_st[MW] == qrs_pkg::ST_ZERO_LEAD) |-> (r_dv_dvs[MW] == '0))
        else $error("zero leading coefficient flag without zero divisor");

    a_div_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dv_vld[MW] && (r_dv_st[MW] == qrs_pkg::ST_OK)
        |-> (r_dv_rlo[MW] < r_dv_dvs[MW]) && (r_dv_rhi[MW] < r_dv_dvs[MW]))
        else $error("divider remainder not below divisor");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_adv |=> $stable(r_sq_vld) && $stable(r_dv_vld))
        else $error("pipeline valid bits moved during a stall");

endmodule
`default_nettype wire

// File: dv/tb_quadratic_root_solver_top.sv
// Testbench: directed table and random equations checked against a built-in root predictor.
`default_nettype none
module tb_quadratic_root_solver_top;

    // Drain allowance well above the pipe latency at defaults.
    localparam int DRAIN_CYCLES  = 200;
    localparam int N_RANDOM      = 650;
    localparam int STALL_LONG    = 400;
    localparam int EXP_DEPTH     = 1024;
    localparam int MAX_ROWS      = 32;

    localparam logic signed [47:0] RMAX = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [47:0] RMIN = -48'sh7FFF_FFFF_FFFF - 48'sd1;

    logic           i_clk;
    logic           i_rst_n;
    logic           i_in_valid;
    logic           o_in_ready;
    qrs_pkg::t_in   i_in_data;
    logic           o_out_valid;
    logic           i_out_ready;
    qrs_pkg::t_out  o_out_data;

    quadratic_root_solver_top DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data (o_out_data)
    );

    always begin
        i_clk = 1'b1; #5;
        i_clk = 1'b0; #5;
    end

    // Idle profiles: percent of cycles each side holds off.
    typedef enum int { PH_NONE, PH_SEND_IDLE, PH_RECV_STALL, PH_BOTH } t_phase;

    // Expected results in acceptance order, ring indexed by running counts.
    qrs_pkg::t_out exp_store [0:EXP_DEPTH-1];
    int    exp_wr     = 0;
    int    exp_rd     = 0;
    int    n_errors   = 0;
    int    n_checked  = 0;
    int    n_sent     = 0;
    int    send_idle_pct = 0;
    int    recv_stall_pct = 0;
    bit    recv_hold  = 1'b0;   // long receiver hold-off when set
    int    n_status[3] = '{0, 0, 0};

    // floor(sqrt(rad) * 2^FRAC_BITS), digit by digit over 2-bit pairs of rad << 2*FRAC_BITS.
    function automatic logic [63:0] isqrt_scaled(input logic [127:0] rad);
        logic [159:0] x;
        logic [95:0]  r;
        logic [97:0]  rem;
        logic [97:0]  trial;
        int k;
        x   = {32'd0, rad} << (2 * qrs_pkg::FRAC_BITS);
        r   = '0;
        rem = '0;
        for (k = 79; k >= 0; k--) begin
            rem   = (rem << 2) | x[2*k +: 2];
            trial = {r, 2'b01};
            if (rem >= trial) begin
                rem = rem - trial;
                r   = {r[94:0], 1'b1};
            end else begin
                r   = {r[94:0], 1'b0};
            end
        end
        return r[63:0];
    endfunction

    function automatic logic signed [47:0] clamp48(input longint v);
        if (v > longint'(RMAX)) return RMAX;
        if (v < longint'(RMIN)) return RMIN;
        return v[47:0];
    endfunction

    // Expected roots and status for one equation.
    function automatic qrs_pkg::t_out solve_roots(input qrs_pkg::t_in eq);
        qrs_pkg::t_out res;
        longint  a, b, e, base, den;
        logic [127:0] disc, bb, four_ae;
        logic [63:0]  s;
        a = eq.coef_a;
        b = eq.coef_b;
        e = longint'(eq.coef_c) - longint'(eq.rhs_value);
        res = '{root_low: '0, root_high: '0, solve_status: qrs_pkg::ST_OK};
        if (a == 0) begin
            res.solve_status = qrs_pkg::ST_ZERO_LEAD;
            return res;
        end
        bb      = 128'(b * b);
        four_ae = 128'((a < 0 ? -a : a) * (e < 0 ? -e : e)) << 2;
        if ((a < 0) != (e < 0) && e != 0) begin
            disc = bb + four_ae;
        end else if (four_ae > bb) begin
            res.solve_status = qrs_pkg::ST_NEG_DISC;
            return res;
        end else begin
            disc = bb - four_ae;
        end
        s    = isqrt_scaled(disc);
        base = -b * (longint'(1) << qrs_pkg::FRAC_BITS);
        den  = 2 * a;
        res.root_low  = clamp48((base - longint'(s)) / den);
        res.root_high = clamp48((base + longint'(s)) / den);
        return res;
    endfunction

    // Directed rows: coefficients, flag for a typed-in expectation, and that expectation.
    typedef struct {
        qrs_pkg::t_in  eq;
        bit            fixed;
        qrs_pkg::t_out want;
    } t_row;

    t_row directed [0:MAX_ROWS-1];
    int   n_rows = 0;

    function automatic qrs_pkg::t_in mk(input int a, input int b, input int c, input int d);
        qrs_pkg::t_in v;
        v.coef_a = a[15:0]; v.coef_b = b[15:0]; v.coef_c = c[15:0]; v.rhs_value = d[15:0];
        return v;
    endfunction

    function automatic qrs_pkg::t_out ok(input longint lo, input longint hi);
        qrs_pkg::t_out v;
        v.root_low = lo[47:0]; v.root_high = hi[47:0]; v.solve_status = qrs_pkg::ST_OK;
        return v;
    endfunction

    localparam qrs_pkg::t_out ZERO_LEAD_RES =
        '{root_low: '0, root_high: '0, solve_status: qrs_pkg::ST_ZERO_LEAD};
    localparam qrs_pkg::t_out NEG_DISC_RES  =
        '{root_low: '0, root_high: '0, solve_status: qrs_pkg::ST_NEG_DISC};

    task automatic add_row(input qrs_pkg::t_in eq, input bit fixed, input qrs_pkg::t_out want);
        directed[n_rows] = '{eq, fixed, want};
        n_rows++;
    endtask

    task automatic build_table();
        add_row(mk(0, 0, 0, 0),               1, ZERO_LEAD_RES);
        add_row(mk(0, -32768, 32767, -32768), 1, ZERO_LEAD_RES);
        add_row(mk(1, 0, 1, 0),               1, NEG_DISC_RES);
        add_row(mk(32767, 0, 32767, -32768),  1, NEG_DISC_RES);
        add_row(mk(-1, 0, 0, 1),              1, NEG_DISC_RES);
        // x^2 - 1 = 0 -> -1, +1
        add_row(mk(1, 0, -1, 0),              1, ok(-65536, 65536));
        // x^2 = 0: zero discriminant
        add_row(mk(1, 0, 0, 0),               1, ok(0, 0));
        // (x-1)^2 = 0 with d shifting the constant
        add_row(mk(1, -2, 5, 4),              1, ok(65536, 65536));
        add_row(mk(1, -3, 2, 0),              1, ok(65536, 131072));
        add_row(mk(-1, 0, 4, 0),              1, ok(131072, -131072));
        add_row(mk(32767, 32767, 32767, 32767), 0, '0);
        add_row(mk(-32768, -32768, 32767, -32768), 0, '0);
        add_row(mk(-32768, 32767, -32768, 32767), 0, '0);
        add_row(mk(1, -32768, -32768, 32767), 0, '0);
        add_row(mk(1, 32767, 0, 0),           0, '0);
        add_row(mk(-1, -32768, 32767, -32768), 0, '0);
        add_row(mk(3, 7, -11, 2),             0, '0);
        add_row(mk(-5, 1, 1, -1),             0, '0);
        add_row(mk(2, 1, 0, 0),               0, '0);
        add_row(mk(-32768, 0, 0, -32768),     0, '0);
        add_row(mk(32767, -1, 1, 0),          0, '0);
        add_row(mk(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA), 0, '0);
    endtask

    // Mix of small coefficients (meaningful roots), full range, and edge values.
    function automatic logic [15:0] rand_coef();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return 16'($signed($urandom_range(0, 40)) - 20);
            4:          return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
            default:    return 16'($urandom);
        endcase
    endfunction

    function automatic qrs_pkg::t_in rand_eq();
        qrs_pkg::t_in v;
        v.coef_a    = rand_coef();
        v.coef_b    = rand_coef();
        v.coef_c    = rand_coef();
        v.rhs_value = rand_coef();
        // Bias toward solvable equations: make a and e opposite in sign.
        if ($urandom_range(0, 2) == 0 && v.coef_a != 0)
            v.rhs_value = (v.coef_a < 0) ? 16'sh8000 : 16'sh7FFF;
        return v;
    endfunction

    // Send one transaction; the expectation is queued at acceptance.
    // Valid stays up after acceptance so back-to-back items need one assignment per edge.
    task automatic send_eq(input qrs_pkg::t_in eq, input bit fixed, input qrs_pkg::t_out want);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= eq;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        exp_store[exp_wr % EXP_DEPTH] = fixed ? want : solve_roots(eq);
        exp_wr++;
        n_sent++;
        @(negedge i_clk);
    endtask

    task automatic stop_send();
        i_in_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (exp_wr != exp_rd) @(negedge i_clk);
    endtask

    task automatic set_phase(input t_phase ph);
        case (ph)
            PH_NONE:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            PH_SEND_IDLE:  begin send_idle_pct = 81; recv_stall_pct = 0;  end
            PH_RECV_STALL: begin send_idle_pct = 0;  recv_stall_pct = 81; end
            PH_BOTH:       begin send_idle_pct = 11; recv_stall_pct = 11; end
        endcase
    endtask

    // Receiver ready driven at the falling edge.
    always @(negedge i_clk) begin
        if (!i_rst_n || recv_hold)
            i_out_ready <= 1'b0;
        else
            i_out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Result checker at the rising edge.
    always @(posedge i_clk) begin
        qrs_pkg::t_out want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (exp_wr == exp_rd) begin
                $display("%0t: unexpected result %p", $time, o_out_data);
                n_errors++;
            end else begin
                want = exp_store[exp_rd % EXP_DEPTH];
                exp_rd++;
                n_checked++;
                if (o_out_data.solve_status <= qrs_pkg::ST_ZERO_LEAD)
                    n_status[o_out_data.solve_status]++;
                if (o_out_data.root_low !== want.root_low) begin
                    $display("%0t: root_low exp %0d got %0d", $time,
                             want.root_low, o_out_data.root_low);
                    n_errors++;
                end
                if (o_out_data.root_high !== want.root_high) begin
                    $display("%0t: root_high exp %0d got %0d", $time,
                             want.root_high, o_out_data.root_high);
                    n_errors++;
                end
                if (o_out_data.solve_status !== want.solve_status) begin
                    $display("%0t: solve_status exp %0d got %0d", $time,
                             want.solve_status, o_out_data.solve_status);
                    n_errors++;
                end
            end
        end
    end

    // Watchdog: far above the slowest correct run.
    initial begin
        #20_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        int i, k, r;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_data   = '0;
        i_out_ready = 1'b0;
        build_table();
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed table, back to back.
        set_phase(PH_NONE);
        for (r = 0; r < n_rows; r++)
            send_eq(directed[r].eq, directed[r].fixed, directed[r].want);
        stop_send();

        // Sender pauses until everything has come back.
        wait_drained();

        // Long receiver hold-off while the sender keeps offering: pipe fills and stalls.
        recv_hold = 1'b1;
        fork
            begin
                repeat (STALL_LONG) @(negedge i_clk);
                recv_hold = 1'b0;
            end
            for (k = 0; k < 100; k++) send_eq(rand_eq(), 1'b0, '0);
        join

        // Random part cycling through the idle profiles.
        for (i = 0; i < N_RANDOM - 100; i++) begin
            if (i % 55 == 0) set_phase(t_phase'((i / 55) % 4));
            send_eq(rand_eq(), 1'b0, '0);
        end
        stop_send();
        set_phase(PH_BOTH);
        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        $display("Sent %0d equations, checked %0d results", n_sent, n_checked);
        $display("Status mix: ok %0d, negative discriminant %0d, zero lead %0d",
                 n_status[0], n_status[1], n_status[2]);
        if (n_errors == 0 && exp_wr == exp_rd)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule
`default_nettype wire
